// ===== rtl/quoted_escape_tokenizer_assert.svh =====
// assertion macros for the quoted escape tokenizer
`ifndef QUOTED_ESCAPE_TOKENIZER_ASSERT_SVH
`define QUOTED_ESCAPE_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define QET_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qet assertion failed");
// next-cycle implication
`define QET_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qet assertion failed");
`else
`define QET_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QET_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/qet_pkg.sv =====
// shared types, codes and helper functions of the quoted escape tokenizer
package qet_pkg;

  localparam int HoldDepthDefault = 16;
  localparam int MaxSeparators    = 8;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_SEP  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // end-of-string status
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_QUOTE = 2'd1;
  localparam logic [1:0] STAT_OVF   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_OPT      = 2'd0;
  localparam logic [1:0] REG_SEP_LIST = 2'd1;
  localparam logic [1:0] REG_SEP_CNT  = 2'd2;

  // option bit positions
  localparam int OPT_TRIM  = 0;
  localparam int OPT_SAME  = 1;
  localparam int OPT_ANY   = 2;
  localparam int OPT_NOOCT = 3;
  localparam int OPT_KEEPQ = 4;

  // escape phases
  localparam logic [2:0] ESC_IDLE  = 3'd0;
  localparam logic [2:0] ESC_START = 3'd1;
  localparam logic [2:0] ESC_OCT2  = 3'd2;
  localparam logic [2:0] ESC_OCT1  = 3'd3;
  localparam logic [2:0] ESC_HEX2  = 3'd4;
  localparam logic [2:0] ESC_HEX1  = 3'd5;

  // open quote codes
  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_DOUBLE = 2'd1;
  localparam logic [1:0] Q_SINGLE = 2'd2;

  typedef struct packed {
    logic [4:0]  opt;
    logic [63:0] sep_list;
    logic [3:0]  sep_cnt;
  } qet_cfg_t;

  typedef struct packed {
    logic [1:0] open_quote;
    logic [2:0] esc_phase;
    logic [7:0] esc_value;
    logic       merge_active;
    logic [7:0] merge_byte;
  } qet_ctx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] total;
    logic [1:0]  status;
  } qet_res_t;

  typedef struct packed {
    qet_ctx_t   ctx;
    logic [1:0] n_emit;
    qet_res_t   r0;
    logic [7:0] b1;
    logic       tally_inc;
  } qet_bu_out_t;

  function automatic logic is_space(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hex_val(logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b1, 4'(b - 8'h30)};
    if (b >= "a" && b <= "f") return {1'b1, 4'(b - 8'h57)};
    if (b >= "A" && b <= "F") return {1'b1, 4'(b - 8'h37)};
    return 5'd0;
  endfunction

  // {hit, decoded value}
  function automatic logic [8:0] esc_letter(logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      "\\":    r = {1'b1, 8'h5c};
      "'":     r = {1'b1, 8'h27};
      "\"":    r = {1'b1, 8'h22};
      "?":     r = {1'b1, 8'h3f};
      "a":     r = {1'b1, 8'd7};
      "b":     r = {1'b1, 8'd8};
      "f":     r = {1'b1, 8'd12};
      "n":     r = {1'b1, 8'd10};
      "r":     r = {1'b1, 8'd13};
      "t":     r = {1'b1, 8'd9};
      "v":     r = {1'b1, 8'd11};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/qet_if.sv =====
// channel interfaces of the quoted escape tokenizer
interface qet_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;
  logic       empty_string;
  modport source (output valid, in_byte, end_of_string, empty_string, input ready);
  modport sink   (input valid, in_byte, end_of_string, empty_string, output ready);
endinterface

interface qet_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] token_total;
  logic [1:0]  status;
  logic        last_of_run;
  modport source (output valid, kind, out_byte, token_total, status, last_of_run,
                  input ready);
  modport sink   (input valid, kind, out_byte, token_total, status, last_of_run,
                  output ready);
endinterface

// ===== rtl/quoted_escape_tokenizer.sv =====
// top level of the quoted escape tokenizer
// usage
//   in_ch carries one string byte per transaction with end_of_string on the
//   final byte, or empty_string alone to close a string with no byte
//   out_ch carries result transactions: token bytes, token boundaries and one
//   end-of-string result with token count and status; last_of_run marks the
//   final result caused by an input transaction
//   cfg_* is an apb port with 64-bit data, registers at byte offsets 0, 8, 16
// sequencing
//   a whitespace byte that is held or dropped passes only decode and done
//   before the next accept; any other byte passes decode, flush check, run,
//   done and idle, flushing each held whitespace byte first (up to
//   HOLD_DEPTH); an escaped separator yields two results, pushed in turn;
//   end of string adds the dangling backslash and end result steps
//   all byte work goes through one shared byte unit under a small sequencer,
//   so in_ch.ready is high only while the sequencer idles
// stalls
//   one result waits in a pending slot so last_of_run is known; when out_ch
//   is stalled the sequencer waits, nothing is dropped
// reset
//   synchronous active-low rst_n clears all string state and restores the
//   default options (space and tab as separators); held bytes need no clear
`include "quoted_escape_tokenizer_assert.svh"
module quoted_escape_tokenizer #(
  parameter int HOLD_DEPTH = qet_pkg::HoldDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  qet_in_if.sink      in_ch,
  qet_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_FIN1  = 3'd4;
  localparam logic [2:0] S_FIN2  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  qet_pkg::qet_cfg_t    cfg;
  qet_pkg::qet_bu_out_t bu;
  logic [7:0]           bu_byte;

  logic [2:0]        st_r, st_nxt;
  qet_pkg::qet_ctx_t ctx_r, ctx_nxt;
  logic              seen_r, seen_nxt;
  logic [7:0]        held_r [HOLD_DEPTH];
  logic [CW-1:0]     held_cnt_r, held_cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [15:0]       tally_r, tally_nxt;
  logic              ovf_r, ovf_nxt;
  logic              sub_r, sub_nxt;
  logic [7:0]        b_r, b_nxt;
  logic              eos_r, eos_nxt;
  logic              empty_r, empty_nxt;
  logic              held_we;

  logic              pend_vld_r;
  qet_pkg::qet_res_t pend_r;
  logic              out_vld_r;
  qet_pkg::qet_res_t out_res_r;
  logic              out_last_r;

  logic              out_free;
  logic              push_ok;
  logic              push;
  qet_pkg::qet_res_t push_res;
  logic              release_last;

  // step of the byte unit
  logic              step_push;
  qet_pkg::qet_res_t step_res;
  logic              step_done;

  qet_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  // flush reads the held store, otherwise the captured byte
  assign bu_byte = (st_r == S_FLUSH) ? held_r[idx_r[IW-1:0]] : b_r;

  qet_byte_unit u_bu (
    .ctx_i  (ctx_r),
    .byte_i (bu_byte),
    .cfg_i  (cfg),
    .res_o  (bu)
  );

  assign out_free = !out_vld_r || out_ch.ready;
  assign push_ok  = !pend_vld_r || out_free;

  // a two-result byte pushes its first result, then its second; state commits with the second
  always_comb begin
    step_push = 1'b0;
    step_res  = bu.r0;
    step_done = 1'b0;
    sub_nxt   = sub_r;
    unique case (bu.n_emit)
      2'd0: step_done = 1'b1;
      2'd1: begin
        if (push_ok) begin
          step_push = 1'b1;
          step_done = 1'b1;
        end
      end
      default: begin
        if (push_ok) begin
          step_push = 1'b1;
          if (!sub_r) begin
            sub_nxt = 1'b1;
          end else begin
            step_res      = '0;
            step_res.kind = qet_pkg::KIND_BYTE;
            step_res.data = bu.b1;
            sub_nxt       = 1'b0;
            step_done     = 1'b1;
          end
        end
      end
    endcase
  end

  // sequencer
  always_comb begin
    st_nxt       = st_r;
    ctx_nxt      = ctx_r;
    seen_nxt     = seen_r;
    held_cnt_nxt = held_cnt_r;
    idx_nxt      = idx_r;
    tally_nxt    = tally_r;
    ovf_nxt      = ovf_r;
    b_nxt        = b_r;
    eos_nxt      = eos_r;
    empty_nxt    = empty_r;
    held_we      = 1'b0;
    push         = 1'b0;
    push_res     = step_res;
    release_last = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          b_nxt     = in_ch.in_byte;
          eos_nxt   = in_ch.end_of_string;
          empty_nxt = in_ch.empty_string;
          st_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        idx_nxt = '0;
        if (empty_r) begin
          st_nxt = S_FIN1;
        end else if (cfg.opt[qet_pkg::OPT_TRIM] && qet_pkg::is_space(b_r)) begin
          if (seen_r && !eos_r) begin
            if (held_cnt_r < CW'(HOLD_DEPTH)) begin
              // hold whitespace until content follows
              held_we      = 1'b1;
              held_cnt_nxt = held_cnt_r + 1'b1;
              st_nxt       = S_DONE;
            end else begin
              // store full: pass everything on as content
              ovf_nxt = 1'b1;
              st_nxt  = S_FLUSH;
            end
          end else begin
            st_nxt = eos_r ? S_FIN1 : S_DONE;
          end
        end else begin
          seen_nxt = 1'b1;
          st_nxt   = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (idx_r < held_cnt_r) begin
          push = step_push;
          if (step_done) begin
            ctx_nxt = bu.ctx;
            if (bu.tally_inc && tally_r != 16'hffff) tally_nxt = tally_r + 16'd1;
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          held_cnt_nxt = '0;
          st_nxt       = S_RUN;
        end
      end
      S_RUN: begin
        push = step_push;
        if (step_done) begin
          ctx_nxt = bu.ctx;
          if (bu.tally_inc && tally_r != 16'hffff) tally_nxt = tally_r + 16'd1;
          st_nxt = eos_r ? S_FIN1 : S_DONE;
        end
      end
      S_FIN1: begin
        // dangling backslash becomes a literal one
        if (ctx_r.esc_phase == qet_pkg::ESC_START) begin
          push_res      = '0;
          push_res.kind = qet_pkg::KIND_BYTE;
          push_res.data = "\\";
          if (push_ok) begin
            push   = 1'b1;
            st_nxt = S_FIN2;
          end
        end else begin
          st_nxt = S_FIN2;
        end
      end
      S_FIN2: begin
        push_res      = '0;
        push_res.kind = qet_pkg::KIND_END;
        push_res.total = !seen_r ? 16'd0 :
                         (tally_r == 16'hffff ? 16'hffff : tally_r + 16'd1);
        push_res.status = (ctx_r.open_quote != qet_pkg::Q_NONE) ? qet_pkg::STAT_QUOTE :
                          (ovf_r ? qet_pkg::STAT_OVF : qet_pkg::STAT_OK);
        if (push_ok) begin
          push         = 1'b1;
          ctx_nxt      = '0;
          seen_nxt     = 1'b0;
          held_cnt_nxt = '0;
          tally_nxt    = 16'd0;
          ovf_nxt      = 1'b0;
          st_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        // pending result is the last one of this transaction
        if (!pend_vld_r) begin
          st_nxt = S_IDLE;
        end else if (out_free) begin
          release_last = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      ctx_r      <= '0;
      seen_r     <= 1'b0;
      held_cnt_r <= '0;
      idx_r      <= '0;
      tally_r    <= 16'd0;
      ovf_r      <= 1'b0;
      sub_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      ctx_r      <= ctx_nxt;
      seen_r     <= seen_nxt;
      held_cnt_r <= held_cnt_nxt;
      idx_r      <= idx_nxt;
      tally_r    <= tally_nxt;
      ovf_r      <= ovf_nxt;
      sub_r      <= ((st_r == S_FLUSH) || (st_r == S_RUN)) ? sub_nxt : sub_r;
      if (push) begin
        pend_vld_r <= 1'b1;
        if (pend_vld_r) out_vld_r <= 1'b1;
        else if (out_ch.ready) out_vld_r <= 1'b0;
      end else if (release_last) begin
        pend_vld_r <= 1'b0;
        out_vld_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    b_r     <= b_nxt;
    eos_r   <= eos_nxt;
    empty_r <= empty_nxt;
    if (held_we) held_r[held_cnt_r[IW-1:0]] <= b_r;
    if (push) begin
      pend_r <= push_res;
      if (pend_vld_r) begin
        out_res_r  <= pend_r;
        out_last_r <= 1'b0;
      end
    end else if (release_last) begin
      out_res_r  <= pend_r;
      out_last_r <= 1'b1;
    end
  end

  assign in_ch.ready        = (st_r == S_IDLE);
  assign out_ch.valid       = out_vld_r;
  assign out_ch.kind        = out_res_r.kind;
  assign out_ch.out_byte    = out_res_r.data;
  assign out_ch.token_total = out_res_r.total;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.last_of_run = out_last_r;

  // nothing pending while a new transaction can be taken
  `QET_ASSERT_IMP(a_idle_no_pend, clk, rst_n, in_ch.ready, !pend_vld_r)
  // held count never passes the store depth
  `QET_ASSERT_IMP(a_held_bound, clk, rst_n, 1'b1, held_cnt_r <= CW'(HOLD_DEPTH))
  // end-of-string result always closes the transaction's results
  `QET_ASSERT_IMP(a_end_last, clk, rst_n,
                  out_vld_r && out_res_r.kind == qet_pkg::KIND_END, out_last_r)
  // an accepted byte is decoded next
  `QET_ASSERT_NXT(a_accept_dec, clk, rst_n, in_ch.valid && in_ch.ready, st_r == S_DEC)

endmodule

// ===== rtl/qet_cfg.sv =====
// apb configuration registers of the quoted escape tokenizer
module qet_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [4:0]       cfg_paddr,
  input  logic [63:0]      cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready,
  output qet_pkg::qet_cfg_t cfg_o
);

  qet_pkg::qet_cfg_t cfg_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:3];
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.opt      <= 5'd0;
      cfg_r.sep_list <= 64'h0920;
      cfg_r.sep_cnt  <= 4'd2;
    end else if (wr_en) begin
      unique case (reg_idx)
        qet_pkg::REG_OPT:      cfg_r.opt      <= cfg_pwdata[4:0];
        qet_pkg::REG_SEP_LIST: cfg_r.sep_list <= cfg_pwdata;
        qet_pkg::REG_SEP_CNT:  cfg_r.sep_cnt  <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      qet_pkg::REG_OPT:      cfg_prdata = {59'd0, cfg_r.opt};
      qet_pkg::REG_SEP_LIST: cfg_prdata = cfg_r.sep_list;
      qet_pkg::REG_SEP_CNT:  cfg_prdata = {60'd0, cfg_r.sep_cnt};
      default:               cfg_prdata = 64'd0;
    endcase
  end

endmodule

// ===== rtl/qet_byte_unit.sv =====
// shared byte unit: quote, escape, separator and merge handling of one byte
module qet_byte_unit (
  input  qet_pkg::qet_ctx_t    ctx_i,
  input  logic [7:0]           byte_i,
  input  qet_pkg::qet_cfg_t    cfg_i,
  output qet_pkg::qet_bu_out_t res_o
);

  logic [3:0]        sep_n;
  logic              sep;
  logic              skip;
  logic              consumed;
  logic              octal;
  logic [4:0]        hv;
  logic [8:0]        let_hit;
  logic [1:0]        q;
  qet_pkg::qet_ctx_t c;

  function automatic logic [3:0] sep_cnt_sat(logic [3:0] n);
    return (n > 4'(qet_pkg::MaxSeparators)) ? 4'(qet_pkg::MaxSeparators) : n;
  endfunction

  assign sep_n = (sep_cnt_sat(cfg_i.sep_cnt));

  always_comb begin
    sep = 1'b0;
    for (int i = 0; i < qet_pkg::MaxSeparators; i++) begin
      if (4'(i) < sep_n && cfg_i.sep_list[8*i +: 8] == byte_i) sep = 1'b1;
    end
  end

  assign octal   = (byte_i >= "0") && (byte_i <= "7");
  assign hv      = qet_pkg::hex_val(byte_i);
  assign let_hit = qet_pkg::esc_letter(byte_i);
  assign q       = (byte_i == "\"") ? qet_pkg::Q_DOUBLE : qet_pkg::Q_SINGLE;

  assign skip = ctx_i.merge_active &&
                (cfg_i.opt[qet_pkg::OPT_SAME] ? (byte_i == ctx_i.merge_byte)
                                               : (cfg_i.opt[qet_pkg::OPT_ANY] && sep));

  always_comb begin
    res_o    = '0;
    res_o.ctx = ctx_i;
    c        = ctx_i;
    consumed = 1'b0;
    if (!skip) begin
      c.merge_active = 1'b0;
      unique case (c.esc_phase)
        qet_pkg::ESC_START: begin
          consumed = 1'b1;
          if (!cfg_i.opt[qet_pkg::OPT_NOOCT] && octal) begin
            c.esc_value = {5'd0, byte_i[2:0]};
            c.esc_phase = qet_pkg::ESC_OCT2;
          end else if (byte_i == "x") begin
            c.esc_value = 8'd0;
            c.esc_phase = qet_pkg::ESC_HEX2;
          end else begin
            c.esc_phase = qet_pkg::ESC_IDLE;
            res_o.r0.kind = qet_pkg::KIND_BYTE;
            if (let_hit[8]) begin
              res_o.n_emit  = 2'd1;
              res_o.r0.data = let_hit[7:0];
            end else if (sep) begin
              // escaped separator keeps its backslash
              res_o.n_emit  = 2'd2;
              res_o.r0.data = "\\";
              res_o.b1      = byte_i;
            end else begin
              res_o.n_emit  = 2'd1;
              res_o.r0.data = byte_i;
            end
          end
        end
        qet_pkg::ESC_OCT2, qet_pkg::ESC_OCT1: begin
          if (!octal) begin
            c.esc_phase = qet_pkg::ESC_IDLE;
          end else begin
            consumed    = 1'b1;
            c.esc_value = {c.esc_value[4:0], byte_i[2:0]};
            if (c.esc_phase == qet_pkg::ESC_OCT1) begin
              res_o.n_emit  = 2'd1;
              res_o.r0.kind = qet_pkg::KIND_BYTE;
              res_o.r0.data = c.esc_value;
              c.esc_phase   = qet_pkg::ESC_IDLE;
            end else begin
              c.esc_phase = qet_pkg::ESC_OCT1;
            end
          end
        end
        qet_pkg::ESC_HEX2, qet_pkg::ESC_HEX1: begin
          if (!hv[4]) begin
            c.esc_phase = qet_pkg::ESC_IDLE;
          end else begin
            consumed    = 1'b1;
            c.esc_value = {c.esc_value[3:0], hv[3:0]};
            if (c.esc_phase == qet_pkg::ESC_HEX1) begin
              res_o.n_emit  = 2'd1;
              res_o.r0.kind = qet_pkg::KIND_BYTE;
              res_o.r0.data = c.esc_value;
              c.esc_phase   = qet_pkg::ESC_IDLE;
            end else begin
              c.esc_phase = qet_pkg::ESC_HEX1;
            end
          end
        end
        default: ;
      endcase
      if (!consumed) begin
        res_o.r0.kind = qet_pkg::KIND_BYTE;
        res_o.r0.data = byte_i;
        if (byte_i == "\"" || byte_i == "'") begin
          if (c.open_quote == qet_pkg::Q_NONE || c.open_quote == q) begin
            c.open_quote = (c.open_quote == qet_pkg::Q_NONE) ? q : qet_pkg::Q_NONE;
            res_o.n_emit = cfg_i.opt[qet_pkg::OPT_KEEPQ] ? 2'd1 : 2'd0;
          end else begin
            res_o.n_emit = 2'd1;
          end
        end else if (byte_i == "\\" && c.open_quote == qet_pkg::Q_NONE) begin
          c.esc_phase = qet_pkg::ESC_START;
        end else if (c.open_quote == qet_pkg::Q_NONE && sep) begin
          res_o.n_emit    = 2'd1;
          res_o.r0.kind   = qet_pkg::KIND_SEP;
          res_o.r0.data   = 8'd0;
          res_o.tally_inc = 1'b1;
          if (cfg_i.opt[qet_pkg::OPT_SAME] || cfg_i.opt[qet_pkg::OPT_ANY]) begin
            c.merge_active = 1'b1;
            c.merge_byte   = byte_i;
          end
        end else begin
          res_o.n_emit = 2'd1;
        end
      end
      res_o.ctx = c;
    end
  end

endmodule

// ===== tb/quoted_escape_tokenizer_tb.sv =====
// self-checking testbench for the quoted escape tokenizer
`timescale 1ns / 1ps
module quoted_escape_tokenizer_tb;

  localparam int HOLD = 16;

  // one input transaction as the driver sees it
  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    logic       empty;
  } str_item_t;

  // one expected result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] total;
    logic [1:0]  status;
    logic        last;
  } tok_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  qet_in_if  in_ch ();
  qet_out_if out_ch ();

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  quoted_escape_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // predictor copy of the configuration
  logic [4:0]  p_opt;
  logic [63:0] p_sep_list;
  logic [3:0]  p_sep_cnt;

  // predictor copy of the string state
  logic [1:0]  p_quote;
  logic [2:0]  p_esc;
  logic [7:0]  p_esc_val;
  logic        p_merge;
  logic [7:0]  p_merge_byte;
  logic        p_seen;
  logic [7:0]  p_held [HOLD];
  int          p_held_n;
  logic [15:0] p_tally;
  logic        p_ovf;

  str_item_t pending_items[$];
  tok_res_t  expected_results[$];
  tok_res_t  step_results[$];
  int        errors = 0;
  bit        idle_enable = 1'b1;
  bit        out_hold = 1'b0;
  int        hold_cycles = 0;
  bit        in_pause = 1'b0;

  function automatic bit ws_byte(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic bit sep_byte(logic [7:0] b);
    int n;
    n = (p_sep_cnt > 8) ? 8 : p_sep_cnt;
    for (int i = 0; i < n; i++)
      if (p_sep_list[8*i +: 8] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - 8'h30;
    if (b >= "a" && b <= "f") return b - 8'h57;
    if (b >= "A" && b <= "F") return b - 8'h37;
    return -1;
  endfunction

  function automatic void push_res(logic [1:0] k, logic [7:0] d, logic [15:0] t,
                                   logic [1:0] s);
    tok_res_t r;
    r = '{kind: k, data: d, total: t, status: s, last: 1'b0};
    step_results.push_back(r);
  endfunction

  // returns 1 when the byte belongs to the escape in progress
  function automatic bit escape_consume(logic [7:0] b);
    int h;
    if (p_esc == qet_pkg::ESC_START) begin
      if (!p_opt[qet_pkg::OPT_NOOCT] && b >= "0" && b <= "7") begin
        p_esc_val = b - 8'h30;
        p_esc = qet_pkg::ESC_OCT2;
        return 1'b1;
      end
      if (b == "x") begin
        p_esc_val = 0;
        p_esc = qet_pkg::ESC_HEX2;
        return 1'b1;
      end
      p_esc = qet_pkg::ESC_IDLE;
      case (b)
        "\\", "'", "\"", "?": begin
          push_res(qet_pkg::KIND_BYTE, b, 0, qet_pkg::STAT_OK);
          return 1'b1;
        end
        "a": begin push_res(qet_pkg::KIND_BYTE, 8'd7, 0, qet_pkg::STAT_OK); return 1'b1; end
        "b": begin push_res(qet_pkg::KIND_BYTE, 8'd8, 0, qet_pkg::STAT_OK); return 1'b1; end
        "f": begin push_res(qet_pkg::KIND_BYTE, 8'd12, 0, qet_pkg::STAT_OK); return 1'b1; end
        "n": begin push_res(qet_pkg::KIND_BYTE, 8'd10, 0, qet_pkg::STAT_OK); return 1'b1; end
        "r": begin push_res(qet_pkg::KIND_BYTE, 8'd13, 0, qet_pkg::STAT_OK); return 1'b1; end
        "t": begin push_res(qet_pkg::KIND_BYTE, 8'd9, 0, qet_pkg::STAT_OK); return 1'b1; end
        "v": begin push_res(qet_pkg::KIND_BYTE, 8'd11, 0, qet_pkg::STAT_OK); return 1'b1; end
        default: ;
      endcase
      // escaped separator keeps its backslash
      if (sep_byte(b)) push_res(qet_pkg::KIND_BYTE, "\\", 0, qet_pkg::STAT_OK);
      push_res(qet_pkg::KIND_BYTE, b, 0, qet_pkg::STAT_OK);
      return 1'b1;
    end
    if (p_esc == qet_pkg::ESC_OCT2 || p_esc == qet_pkg::ESC_OCT1) begin
      if (b < "0" || b > "7") begin
        p_esc = qet_pkg::ESC_IDLE;
        return 1'b0;
      end
      p_esc_val = {p_esc_val[4:0], b[2:0]};
      if (p_esc == qet_pkg::ESC_OCT1) begin
        push_res(qet_pkg::KIND_BYTE, p_esc_val, 0, qet_pkg::STAT_OK);
        p_esc = qet_pkg::ESC_IDLE;
      end else p_esc = qet_pkg::ESC_OCT1;
      return 1'b1;
    end
    if (p_esc == qet_pkg::ESC_HEX2 || p_esc == qet_pkg::ESC_HEX1) begin
      h = hex_digit(b);
      if (h < 0) begin
        p_esc = qet_pkg::ESC_IDLE;
        return 1'b0;
      end
      p_esc_val = {p_esc_val[3:0], 4'(h)};
      if (p_esc == qet_pkg::ESC_HEX1) begin
        push_res(qet_pkg::KIND_BYTE, p_esc_val, 0, qet_pkg::STAT_OK);
        p_esc = qet_pkg::ESC_IDLE;
      end else p_esc = qet_pkg::ESC_HEX1;
      return 1'b1;
    end
    p_esc = qet_pkg::ESC_IDLE;
    return 1'b0;
  endfunction

  task automatic tokenize_byte(logic [7:0] b);
    logic [1:0] q;
    bit skip;
    if (p_merge) begin
      skip = p_opt[qet_pkg::OPT_SAME] ? (b == p_merge_byte)
                                      : (p_opt[qet_pkg::OPT_ANY] && sep_byte(b));
      if (skip) return;
      p_merge = 1'b0;
    end
    if (p_esc != qet_pkg::ESC_IDLE && escape_consume(b)) return;
    if (b == "\"" || b == "'") begin
      q = (b == "\"") ? qet_pkg::Q_DOUBLE : qet_pkg::Q_SINGLE;
      if (p_quote == qet_pkg::Q_NONE || p_quote == q) begin
        p_quote = (p_quote == qet_pkg::Q_NONE) ? q : qet_pkg::Q_NONE;
        if (p_opt[qet_pkg::OPT_KEEPQ]) push_res(qet_pkg::KIND_BYTE, b, 0, qet_pkg::STAT_OK);
      end else push_res(qet_pkg::KIND_BYTE, b, 0, qet_pkg::STAT_OK);
    end else if (b == "\\" && p_quote == qet_pkg::Q_NONE) begin
      p_esc = qet_pkg::ESC_START;
    end else if (p_quote == qet_pkg::Q_NONE && sep_byte(b)) begin
      push_res(qet_pkg::KIND_SEP, 0, 0, qet_pkg::STAT_OK);
      if (p_tally != 16'hffff) p_tally++;
      if (p_opt[qet_pkg::OPT_SAME] || p_opt[qet_pkg::OPT_ANY]) begin
        p_merge = 1'b1;
        p_merge_byte = b;
      end
    end else push_res(qet_pkg::KIND_BYTE, b, 0, qet_pkg::STAT_OK);
  endtask

  task automatic release_held();
    for (int i = 0; i < p_held_n; i++) tokenize_byte(p_held[i]);
    p_held_n = 0;
  endtask

  task automatic clear_string_state();
    p_quote = qet_pkg::Q_NONE;
    p_esc = qet_pkg::ESC_IDLE;
    p_esc_val = 0;
    p_merge = 1'b0;
    p_merge_byte = 0;
    p_seen = 1'b0;
    p_held_n = 0;
    p_tally = 0;
    p_ovf = 1'b0;
  endtask

  // works out the results of one accepted input transaction
  task automatic predict_tokens(str_item_t it);
    logic [15:0] tot;
    logic [1:0]  st;
    step_results.delete();
    if (!it.empty) begin
      if (p_opt[qet_pkg::OPT_TRIM] && ws_byte(it.b)) begin
        if (p_seen && !it.eos) begin
          if (p_held_n < HOLD) begin
            p_held[p_held_n] = it.b;
            p_held_n++;
          end else begin
            p_ovf = 1'b1;
            release_held();
            tokenize_byte(it.b);
          end
        end
      end else begin
        release_held();
        p_seen = 1'b1;
        tokenize_byte(it.b);
      end
    end
    if (it.empty || it.eos) begin
      p_held_n = 0;
      if (p_esc == qet_pkg::ESC_START) push_res(qet_pkg::KIND_BYTE, "\\", 0, qet_pkg::STAT_OK);
      tot = !p_seen ? 16'd0 : (p_tally == 16'hffff ? 16'hffff : p_tally + 16'd1);
      st = (p_quote != qet_pkg::Q_NONE) ? qet_pkg::STAT_QUOTE :
           (p_ovf ? qet_pkg::STAT_OVF : qet_pkg::STAT_OK);
      push_res(qet_pkg::KIND_END, 0, tot, st);
      clear_string_state();
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  // input driver: offers queued transactions, random idle bursts
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_tokens(pending_items.pop_front());
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 5);
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0 && !in_pause) begin
        in_ch.valid <= 1'b1;
        {in_ch.in_byte, in_ch.end_of_string, in_ch.empty_string}
          <= pending_items[0];
      end else in_ch.valid <= 1'b0;
    end
  end
  // the driver predicts at acceptance, so the head of the queue is the item on the bus

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.end_of_string = 1'b0;
    in_ch.empty_string = 1'b0;
    out_ch.ready = 1'b0;
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles--;
    out_hold = (hold_cycles > 0);
  end

  // result monitor: random stall bursts, long hold-off on request
  int out_gap = 0;
  always @(posedge clk) begin
    tok_res_t got, exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{kind: out_ch.kind, data: out_ch.out_byte, total: out_ch.token_total,
              status: out_ch.status, last: out_ch.last_of_run};
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %p", $time, got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got.kind !== exp_r.kind || got.data !== exp_r.data || got.total !== exp_r.total
            || got.status !== exp_r.status || got.last !== exp_r.last) begin
          errors++;
          $display("%0t result mismatch: expected %p, actual %p", $time, exp_r, got);
        end
      end
    end
    if (!rst_n || out_hold) out_ch.ready <= 1'b0;
    else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= 1'b1;
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      qet_pkg::REG_OPT:      p_opt = val[4:0];
      qet_pkg::REG_SEP_LIST: p_sep_list = val;
      default:               p_sep_cnt = val[3:0];
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    // a trailing held byte may still be in the sequencer
    repeat (HOLD + 10) @(posedge clk);
  endtask

  task automatic add_item(logic [7:0] b, bit eos, bit empty);
    pending_items.push_back('{b: b, eos: eos, empty: empty});
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], i == s.len() - 1, 1'b0);
  endtask

  // random byte drawn mostly from the interesting alphabet
  function automatic logic [7:0] pick_byte();
    string alpha;
    alpha = "ab \t\\\"'x07Fnq,;:";
    if ($urandom_range(0, 5) == 0) return 8'($urandom);
    return alpha[$urandom_range(0, alpha.len() - 1)];
  endfunction

  // well-formed string with random content, occasional noise
  task automatic add_random_string(int n);
    int len;
    len = $urandom_range(1, 6);
    if ($urandom_range(0, 19) == 0) len = $urandom_range(20, 30);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0: add_text($sformatf("\\%0o%0o%0o", $urandom_range(0, 3), $urandom_range(0, 7),
                              $urandom_range(0, 7)));
        1: add_text($sformatf("\\x%02x", $urandom_range(0, 255)));
        2: add_text("\"a b\"");
        default: add_item(pick_byte(), 1'b0, 1'b0);
      endcase
      // add_text set eos on its last byte; clear it mid-string
      pending_items[pending_items.size()-1].eos = 1'b0;
    end
    if ($urandom_range(0, 3) == 0) add_item(8'($urandom), 1'b0, 1'b1);
    else add_item(pick_byte(), 1'b1, $urandom_range(0, 1));
  endtask

  task automatic random_config();
    reg_write(qet_pkg::REG_OPT, 64'($urandom_range(0, 31)));
    reg_write(qet_pkg::REG_SEP_LIST, {$urandom, 8'h3b, 8'h2c, 8'h09, 8'h20} ^
              ($urandom_range(0, 3) == 0 ? {$urandom, $urandom} : 64'd0));
    reg_write(qet_pkg::REG_SEP_CNT, 64'($urandom_range(0, 15)));
  endtask

  initial begin
    p_opt = 5'd0;
    p_sep_list = 64'h0920;
    p_sep_cnt = 4'd2;
    clear_string_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under reset options
    add_text("ab c\\n\\x4G\\101\\4q\\ \\\\\"d\\\"e\"'un");
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'h5c, 1'b1, 1'b0);
    drain();

    // trim, merge same and any (same wins), keep quotes, no octal, max separators
    reg_write(qet_pkg::REG_OPT, 64'h1f);
    reg_write(qet_pkg::REG_SEP_LIST, 64'hffff_2227_2c3b_0920);
    reg_write(qet_pkg::REG_SEP_CNT, 64'd15);
    add_text("  a\"b c\"\\101,,; \t x  ");
    // hold store overflow: seventeen spaces after content
    add_item("z", 1'b0, 1'b0);
    for (int i = 0; i < 17; i++) add_item(" ", 1'b0, 1'b0);
    add_item("y", 1'b1, 1'b0);
    drain();
    reg_write(qet_pkg::REG_OPT, 64'h02);
    reg_write(qet_pkg::REG_SEP_CNT, 64'd0);
    add_text("a  b\\777");
    drain();

    // long receiver hold-off while the sender keeps offering
    for (int i = 0; i < 8; i++) add_random_string(i);
    hold_cycles = 300;
    @(posedge clk);
    while (hold_cycles > 0) @(posedge clk);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      random_config();
      for (int i = 0; i < 3; i++) add_random_string(i);
      // sender pause until every expected result has come
      if (ph == 2) begin
        while (pending_items.size() > 15) @(posedge clk);
        in_pause = 1'b1;
        while (in_ch.valid || expected_results.size() > 0) @(posedge clk);
        in_pause = 1'b0;
      end
      drain();
    end
    idle_enable = 1'b0;
    reg_write(qet_pkg::REG_OPT, 64'h00);
    reg_write(qet_pkg::REG_SEP_LIST, 64'h0920);
    reg_write(qet_pkg::REG_SEP_CNT, 64'd2);
    for (int i = 0; i < 4; i++) add_random_string(i);
    drain();

    if (errors == 0) $display("quoted_escape_tokenizer: match");
    else $display("quoted_escape_tokenizer: mismatch");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("quoted_escape_tokenizer: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/qet_pkg.sv
rtl/qet_if.sv
rtl/qet_cfg.sv
rtl/qet_byte_unit.sv
rtl/quoted_escape_tokenizer.sv
tb/quoted_escape_tokenizer_tb.sv
